FILE: hdl/ezr_pkg.sv
// ezr_pkg: shared types and constants for the zxz euler angle to rotation matrix block
// holds the word structs, fixed-point widths and the cordic arctangent table
// no dependencies
package ezr_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int QW = 33;          // q2.30 trig value with headroom
	localparam int PW = 66;          // q60 product
	localparam int SW = 67;          // q60 sum of two products

	localparam logic signed [QW-1:0] CORDIC_GAIN = 33'sd652032874;

	typedef struct packed {
		logic [15:0] psi_angle;
		logic [15:0] theta_angle;
		logic [15:0] phi_angle;
	} args_t;

	typedef struct packed {
		logic signed [15:0] row0_col0;
		logic signed [15:0] row0_col1;
		logic signed [15:0] row0_col2;
		logic signed [15:0] row1_col0;
		logic signed [15:0] row1_col1;
		logic signed [15:0] row1_col2;
		logic signed [15:0] row2_col0;
		logic signed [15:0] row2_col1;
		logic signed [15:0] row2_col2;
	} matrix_t;

	// arctangent of 2^-i in 2^32-per-turn units
	function automatic logic signed [QW-1:0] atan_turn(input logic [4:0] idx);
		logic signed [QW-1:0] r;
		case (idx)
			5'd0:  r = 33'sd536870912;
			5'd1:  r = 33'sd316933406;
			5'd2:  r = 33'sd167458907;
			5'd3:  r = 33'sd85004756;
			5'd4:  r = 33'sd42667331;
			5'd5:  r = 33'sd21354465;
			5'd6:  r = 33'sd10679838;
			5'd7:  r = 33'sd5340245;
			5'd8:  r = 33'sd2670163;
			5'd9:  r = 33'sd1335087;
			5'd10: r = 33'sd667544;
			5'd11: r = 33'sd333772;
			5'd12: r = 33'sd166886;
			5'd13: r = 33'sd83443;
			5'd14: r = 33'sd41722;
			5'd15: r = 33'sd20861;
			5'd16: r = 33'sd10430;
			5'd17: r = 33'sd5215;
			5'd18: r = 33'sd2608;
			5'd19: r = 33'sd1304;
			5'd20: r = 33'sd652;
			5'd21: r = 33'sd326;
			5'd22: r = 33'sd163;
			5'd23: r = 33'sd81;
			5'd24: r = 33'sd41;
			5'd25: r = 33'sd20;
			5'd26: r = 33'sd10;
			5'd27: r = 33'sd5;
			5'd28: r = 33'sd3;
			5'd29: r = 33'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/ezr_cordic.sv
// ezr_cordic: pipelined rotation-mode cordic giving cosine and sine of a binary angle
// one iteration per register stage plus input and quadrant stages; uses ezr_pkg
module ezr_cordic #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                             clk,
	input  logic [15:0]                      angle,
	output logic signed [ezr_pkg::QW-1:0]    cos_val,
	output logic signed [ezr_pkg::QW-1:0]    sin_val
);

	localparam int N = ezr_pkg::CORDIC_STEPS;

	logic [31:0] masked;
	logic [31:0] turn;

	logic signed [ezr_pkg::QW-1:0] x_s [0:N];
	logic signed [ezr_pkg::QW-1:0] y_s [0:N];
	logic signed [ezr_pkg::QW-1:0] z_s [0:N];
	logic [1:0]                    quad_s [0:N];

	// scale angle to 2^32 per turn
	always_comb begin
		masked = {16'b0, angle} & ((32'd1 << ANGLE_BITS) - 32'd1);
		turn   = masked << (32 - ANGLE_BITS);
	end

	// input stage
	always_ff @(posedge clk) begin
		x_s[0]    <= ezr_pkg::CORDIC_GAIN;
		y_s[0]    <= '0;
		z_s[0]    <= ezr_pkg::QW'(turn[29:0]);
		quad_s[0] <= turn[31:30];
	end

	// one micro-rotation per stage, shifts floor toward minus infinity
	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (!z_s[i][ezr_pkg::QW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ezr_pkg::atan_turn(5'(i));
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ezr_pkg::atan_turn(5'(i));
			end
			quad_s[i+1] <= quad_s[i];
		end
	end

	// quadrant fold
	always_ff @(posedge clk) begin
		case (quad_s[N])
			2'd0: begin
				cos_val <= x_s[N];
				sin_val <= y_s[N];
			end
			2'd1: begin
				cos_val <= -y_s[N];
				sin_val <= x_s[N];
			end
			2'd2: begin
				cos_val <= -x_s[N];
				sin_val <= -y_s[N];
			end
			default: begin
				cos_val <= y_s[N];
				sin_val <= -x_s[N];
			end
		endcase
	end

endmodule

FILE: hdl/euler_zxz_to_rotation_matrix_top.sv
// euler_zxz_to_rotation_matrix_top: zxz euler angles to rotation matrix in signed q1.14
// three ezr_cordic pipelines feed a five-stage multiply and round pipeline; uses ezr_pkg
//
// usage:
//   raise start with an angle word on args; the word is taken at that clock edge.
//   busy is always low, so a new word may be taken in every cycle.
//   one matrix word per taken angle word appears on result with done high for
//   exactly one cycle.
//   throughput is one word per cycle; the path runs through the 30-stage cordic
//   (plus its input and quadrant stages) and five stages of multiply, round
//   and saturate.
//   reset clears only the valid bits of the pipeline; words in flight are dropped
//   and done stays low until new words come through.
//   the receiver cannot stall, so result must be taken in the cycle done is high.
//   entries are rounded to nearest (ties upward) and clamped to +-2^FRAC_BITS.
module euler_zxz_to_rotation_matrix_top #(
	parameter int ANGLE_BITS = 16,
	parameter int FRAC_BITS  = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ezr_pkg::args_t   args,
	output logic             done,
	output ezr_pkg::matrix_t result
);

	localparam int QW  = ezr_pkg::QW;
	localparam int PW  = ezr_pkg::PW;
	localparam int SW  = ezr_pkg::SW;
	localparam int CL  = ezr_pkg::CORDIC_STEPS + 2;
	localparam logic signed [PW-1:0] HALF30 = PW'(1) <<< 29;
	localparam logic signed [SW-1:0] HALF_O = SW'(1) <<< (59 - FRAC_BITS);
	localparam logic signed [SW-1:0] ONE_O  = SW'(1) <<< FRAC_BITS;

	logic signed [QW-1:0] psc, pss, thc, ths, phc, phs;

	logic [CL-1:0] vld_s;
	logic          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// stage 1 products
	logic signed [PW-1:0] pcs_s1, pcc_s1, a_s1, b_s1, c_s1, d_s1, e_s1, f_s1, g_s1, h_s1, k_s1;
	logic signed [QW-1:0] psc_s1, pss_s1;
	// stage 2 rounded inner products
	logic signed [QW-1:0] cs_s2, cc_s2, psc_s2, pss_s2;
	logic signed [PW-1:0] a_s2, b_s2, c_s2, d_s2, e_s2, f_s2, g_s2, h_s2, k_s2;
	// stage 3 triple products
	logic signed [PW-1:0] t0_s3, t1_s3, t2_s3, t3_s3;
	logic signed [PW-1:0] a_s3, b_s3, c_s3, d_s3, e_s3, f_s3, g_s3, h_s3, k_s3;
	// stage 4 sums, stage 5 finished entries
	logic signed [SW-1:0] sum_s4 [0:8];
	logic signed [SW-1:0] rnd    [0:8];
	logic signed [15:0]   ent_s5 [0:8];

	assign busy = 1'b0;

	ezr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_psi (
		.clk(clk), .angle(args.psi_angle), .cos_val(psc), .sin_val(pss));
	ezr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_theta (
		.clk(clk), .angle(args.theta_angle), .cos_val(thc), .sin_val(ths));
	ezr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_phi (
		.clk(clk), .angle(args.phi_angle), .cos_val(phc), .sin_val(phs));

	// valid bits alongside the cordic and the arithmetic stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s  <= {vld_s[CL-2:0], start & ~busy};
			vld_s1 <= vld_s[CL-1];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// stage 1: pairwise products in q60
	always_ff @(posedge clk) begin
		pcs_s1 <= thc * phs;
		pcc_s1 <= thc * phc;
		a_s1   <= psc * phc;
		b_s1   <= pss * phc;
		c_s1   <= psc * phs;
		d_s1   <= pss * phs;
		e_s1   <= phs * ths;
		f_s1   <= phc * ths;
		g_s1   <= ths * pss;
		h_s1   <= ths * psc;
		k_s1   <= PW'(thc) <<< 30;
		psc_s1 <= psc;
		pss_s1 <= pss;
	end

	// stage 2: round inner products back to q30
	always_ff @(posedge clk) begin
		cs_s2  <= QW'((pcs_s1 + HALF30) >>> 30);
		cc_s2  <= QW'((pcc_s1 + HALF30) >>> 30);
		psc_s2 <= psc_s1;
		pss_s2 <= pss_s1;
		a_s2 <= a_s1; b_s2 <= b_s1; c_s2 <= c_s1; d_s2 <= d_s1; e_s2 <= e_s1;
		f_s2 <= f_s1; g_s2 <= g_s1; h_s2 <= h_s1; k_s2 <= k_s1;
	end

	// stage 3: triple products
	always_ff @(posedge clk) begin
		t0_s3 <= cs_s2 * pss_s2;
		t1_s3 <= cs_s2 * psc_s2;
		t2_s3 <= cc_s2 * pss_s2;
		t3_s3 <= cc_s2 * psc_s2;
		a_s3 <= a_s2; b_s3 <= b_s2; c_s3 <= c_s2; d_s3 <= d_s2; e_s3 <= e_s2;
		f_s3 <= f_s2; g_s3 <= g_s2; h_s3 <= h_s2; k_s3 <= k_s2;
	end

	// stage 4: matrix entry sums
	always_ff @(posedge clk) begin
		sum_s4[0] <= SW'(a_s3) - SW'(t0_s3);
		sum_s4[1] <= SW'(b_s3) + SW'(t1_s3);
		sum_s4[2] <= SW'(e_s3);
		sum_s4[3] <= -SW'(c_s3) - SW'(t2_s3);
		sum_s4[4] <= -SW'(d_s3) + SW'(t3_s3);
		sum_s4[5] <= SW'(f_s3);
		sum_s4[6] <= SW'(g_s3);
		sum_s4[7] <= -SW'(h_s3);
		sum_s4[8] <= SW'(k_s3);
	end

	// stage 5: round to output fraction and clamp
	always_comb begin
		for (int j = 0; j < 9; j++) begin
			rnd[j] = (sum_s4[j] + HALF_O) >>> (60 - FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 9; j++) begin
			if (rnd[j] > ONE_O)
				ent_s5[j] <= ONE_O[15:0];
			else if (rnd[j] < -ONE_O)
				ent_s5[j] <= 16'(-ONE_O);
			else
				ent_s5[j] <= rnd[j][15:0];
		end
	end

	// output word
	assign done             = vld_s5;
	assign result.row0_col0 = ent_s5[0];
	assign result.row0_col1 = ent_s5[1];
	assign result.row0_col2 = ent_s5[2];
	assign result.row1_col0 = ent_s5[3];
	assign result.row1_col1 = ent_s5[4];
	assign result.row1_col2 = ent_s5[5];
	assign result.row2_col0 = ent_s5[6];
	assign result.row2_col1 = ent_s5[7];
	assign result.row2_col2 = ent_s5[8];

endmodule

FILE: bench/ezr_matrix_checker.sv
// ezr_matrix_checker: watches the angle and matrix words of the euler zxz block,
// predicts each rotation matrix in fixed point and compares it field by field
// depends on ezr_pkg
module ezr_matrix_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  ezr_pkg::args_t   args,
	input  logic             done,
	input  ezr_pkg::matrix_t result,
	output int               fail_count,
	output int               pending_count
);

	localparam longint ATAN_TURNS [30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1
	};

	ezr_pkg::matrix_t expected_matrices[$];

	// round to nearest, ties upward; the arithmetic shift on longint floors toward minus infinity
	function automatic longint rnd_shift(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// sine and cosine in q30 from a 16-bit binary angle
	function automatic void angle_sincos(input logic [15:0] ang,
			output longint c, output longint s);
		logic [31:0] turn_units;
		longint x, y, z, nx, ny;
		turn_units = {ang, 16'h0};
		z = longint'(turn_units[29:0]);
		x = 652032874;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= ATAN_TURNS[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += ATAN_TURNS[i];
			end
			x = nx;
			y = ny;
		end
		case (turn_units[31:30])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	// q60 sum to q1.14, rounded and clamped to plus or minus one
	function automatic logic signed [15:0] to_q14(input longint q60);
		longint v;
		v = rnd_shift(q60, 46);
		if (v > 16384) v = 16384;
		if (v < -16384) v = -16384;
		return v[15:0];
	endfunction

	function automatic ezr_pkg::matrix_t zxz_matrix(input ezr_pkg::args_t a);
		longint cpsi, spsi, cth, sth, cphi, sphi, cs, cc;
		ezr_pkg::matrix_t m;
		angle_sincos(a.psi_angle, cpsi, spsi);
		angle_sincos(a.theta_angle, cth, sth);
		angle_sincos(a.phi_angle, cphi, sphi);
		cs = rnd_shift(cth * sphi, 30);
		cc = rnd_shift(cth * cphi, 30);
		m.row0_col0 = to_q14(cpsi * cphi - cs * spsi);
		m.row0_col1 = to_q14(spsi * cphi + cs * cpsi);
		m.row0_col2 = to_q14(sphi * sth);
		m.row1_col0 = to_q14(-(cpsi * sphi) - cc * spsi);
		m.row1_col1 = to_q14(-(spsi * sphi) + cc * cpsi);
		m.row1_col2 = to_q14(cphi * sth);
		m.row2_col0 = to_q14(sth * spsi);
		m.row2_col1 = to_q14(-(sth * cpsi));
		m.row2_col2 = to_q14(cth * (longint'(1) << 30));
		return m;
	endfunction

	function automatic logic [15:0] field_of(input ezr_pkg::matrix_t m, input int k);
		logic [143:0] flat;
		flat = m;
		return flat[143 - 16*k -: 16];
	endfunction

	assign pending_count = expected_matrices.size();

	// queue predictions for taken words, compare each matrix word
	always @(posedge clk or negedge arst_n) begin
		ezr_pkg::matrix_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (start && !busy)
				expected_matrices.push_back(zxz_matrix(args));
			if (done) begin
				if (expected_matrices.size() == 0) begin
					if (fail_count < 10)
						$display("matrix word with none expected: %h", result);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_matrices.pop_front();
					if (want !== result) begin
						if (fail_count < 10)
							for (int k = 0; k < 9; k++)
								if (field_of(want, k) !== field_of(result, k))
									$display("entry r%0dc%0d: expected %0d got %0d",
										k / 3, k % 3, $signed(field_of(want, k)),
										$signed(field_of(result, k)));
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

FILE: bench/tb_euler_zxz_to_rotation_matrix_top.sv
// tb_euler_zxz_to_rotation_matrix_top: drives angle words into the block and gives the verdict
// depends on ezr_pkg, euler_zxz_to_rotation_matrix_top and ezr_matrix_checker
module tb_euler_zxz_to_rotation_matrix_top;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	ezr_pkg::args_t   args;
	logic             done;
	ezr_pkg::matrix_t result;
	int               fail_count;
	int               pending_count;
	int               cycle_count = 0;

	euler_zxz_to_rotation_matrix_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.args(args), .done(done), .result(result)
	);

	ezr_matrix_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .args(args),
		.done(done), .result(result), .fail_count(fail_count),
		.pending_count(pending_count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 200000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// random angles, one in six picked near quadrant edges and extremes
	function automatic logic [15:0] pick_angle();
		logic [15:0] corners [10] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
			16'h3FFF, 16'h7FFF, 16'hBFFF, 16'h0001, 16'h2000};
		if ($urandom_range(0, 5) == 0)
			return corners[$urandom_range(0, 9)] + 16'($urandom_range(0, 2)) - 16'd1;
		return 16'($urandom);
	endfunction

	// present one angle word, with random idle cycles unless burst is set
	task automatic send_angles(input ezr_pkg::args_t a, input bit burst);
		while (!burst && $urandom_range(0, 99) < 38) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		args  <= a;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	initial begin
		logic [15:0] dir_angles [8] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
			16'hC000, 16'h2000, 16'h5555, 16'hAAAA};
		ezr_pkg::args_t a;
		arst_n = 1'b0;
		start  = 1'b0;
		args   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: quadrant edges and extremes on each angle
		for (int i = 0; i < 8; i++) begin
			a = '{dir_angles[i], dir_angles[(i + 3) % 8], dir_angles[(i + 5) % 8]};
			send_angles(a, 1'b0);
		end
		for (int i = 0; i < 8; i++) begin
			a = '{dir_angles[i], dir_angles[i], dir_angles[i]};
			send_angles(a, 1'b1);
		end
		// random, with a long burst in the middle
		for (int n = 0; n < 750; n++) begin
			a = '{pick_angle(), pick_angle(), pick_angle()};
			send_angles(a, n >= 300 && n < 450);
		end
		start <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

FILE: files.f
hdl/ezr_pkg.sv
hdl/ezr_cordic.sv
hdl/euler_zxz_to_rotation_matrix_top.sv
bench/ezr_matrix_checker.sv
bench/tb_euler_zxz_to_rotation_matrix_top.sv
